>>> rtl/hid_gamepad_report_mapper_macros.svh
// ----------------------------------------------------------------------------
// hid_gamepad_report_mapper_macros.svh
// Assertion macros for the gamepad report mapper. All use clk and rst_n of
// the including module. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef HID_GAMEPAD_REPORT_MAPPER_MACROS_SVH
`define HID_GAMEPAD_REPORT_MAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HGRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgrm assertion failed");

// next-cycle implication
`define HGRM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgrm assertion failed");

`else

`define HGRM_ASSERT_IMP(lbl, ante, cons)
`define HGRM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/hgrm_pkg.sv
// ----------------------------------------------------------------------------
// hgrm_pkg
// Types, usage codes and lookup functions for the gamepad report mapper.
// ----------------------------------------------------------------------------
package hgrm_pkg;

    localparam int USAGE_W   = 16;
    localparam int VAL_W     = 32;
    localparam int S_TDATA_W = 112;  // usage, raw_value, logical_min, logical_max
    localparam int S_TUSER_W = 2;    // op, first_in_report
    localparam int M_TDATA_W = 96;   // buttons, triggers, four stick axes

    // scaling datapath
    localparam int RANGE_W   = 33;   // max - min never wraps at 33 bits
    localparam int NUM_W     = 50;   // magnitude of the scaled numerator
    localparam int DEN_W     = 32;   // magnitude of the range
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic OP_BUTTON = 1'b0;
    localparam logic OP_VALUE  = 1'b1;

    localparam logic [USAGE_W-1:0] USAGE_X     = 16'h0030;
    localparam logic [USAGE_W-1:0] USAGE_Y     = 16'h0031;
    localparam logic [USAGE_W-1:0] USAGE_Z     = 16'h0032;
    localparam logic [USAGE_W-1:0] USAGE_RX    = 16'h0033;
    localparam logic [USAGE_W-1:0] USAGE_RY    = 16'h0034;
    localparam logic [USAGE_W-1:0] USAGE_RZ    = 16'h0035;
    localparam logic [USAGE_W-1:0] USAGE_SLIDE = 16'h0036;
    localparam logic [USAGE_W-1:0] USAGE_DIAL  = 16'h0037;
    localparam logic [USAGE_W-1:0] USAGE_HAT   = 16'h0039;
    localparam logic [USAGE_W-1:0] USAGE_BRAKE = 16'h00c5;
    localparam logic [USAGE_W-1:0] USAGE_ACCEL = 16'h00c4;

    localparam logic signed [15:0] STICK_MAX = 16'sh7FFF;
    localparam logic signed [15:0] STICK_MIN = -16'sh8000;
    localparam logic [7:0]         TRIG_MID  = 8'd127;
    localparam logic [7:0]         TRIG_MAX  = 8'd255;

    typedef enum logic [3:0] {
        TGT_NONE,
        TGT_BUTTON,
        TGT_LX,
        TGT_LY,
        TGT_RX,
        TGT_RY,
        TGT_LT,
        TGT_RT,
        TGT_HAT
    } target_t;

    function automatic target_t decode_target(input logic op,
                                              input logic [USAGE_W-1:0] usage);
        target_t t;
        if (op == OP_BUTTON)
        begin
            t = TGT_BUTTON;
        end
        else
        begin
            unique case (usage)
                USAGE_X:                          t = TGT_LX;
                USAGE_Y:                          t = TGT_LY;
                USAGE_Z:                          t = TGT_RX;
                USAGE_RZ:                         t = TGT_RY;
                USAGE_RX, USAGE_SLIDE, USAGE_BRAKE: t = TGT_LT;
                USAGE_RY, USAGE_DIAL, USAGE_ACCEL:  t = TGT_RT;
                USAGE_HAT:                        t = TGT_HAT;
                default:                          t = TGT_NONE;
            endcase
        end
        return t;
    endfunction

    function automatic logic [15:0] button_bit(input logic [USAGE_W-1:0] usage);
        logic [15:0] b;
        unique case (usage)
            16'd1:   b = 16'h1000;  // A
            16'd2:   b = 16'h2000;  // B
            16'd4:   b = 16'h4000;  // X
            16'd5:   b = 16'h8000;  // Y
            16'd7:   b = 16'h0100;  // left shoulder
            16'd8:   b = 16'h0200;  // right shoulder
            16'd11:  b = 16'h0020;  // back
            16'd12:  b = 16'h0010;  // start
            16'd14:  b = 16'h0040;  // left thumb
            16'd15:  b = 16'h0080;  // right thumb
            default: b = 16'h0000;
        endcase
        return b;
    endfunction

    // hat position to D-pad bits (up, down, left, right in bits 0..3)
    function automatic logic [15:0] hat_bits(input logic [VAL_W-1:0] h);
        logic [15:0] b;
        if (h > 32'd7)
        begin
            b = 16'h0000;
        end
        else
        begin
            unique case (h[2:0])
                3'd0: b = 16'h0001;
                3'd1: b = 16'h0009;
                3'd2: b = 16'h0008;
                3'd3: b = 16'h000A;
                3'd4: b = 16'h0002;
                3'd5: b = 16'h0006;
                3'd6: b = 16'h0004;
                3'd7: b = 16'h0005;
                default: b = 16'h0000;
            endcase
        end
        return b;
    endfunction

endpackage

>>> rtl/hid_gamepad_report_mapper.sv
// ----------------------------------------------------------------------------
// hid_gamepad_report_mapper
// Maps decoded HID usages onto a gamepad report: button bits, D-pad from the
// hat switch, triggers scaled to 0..255, sticks scaled to signed 16 bits.
//
//   channel  dir  payload (low bits first)
//   s_axis   in   tuser: op, first_in_report
//                 tdata: usage, raw_value, logical_min, logical_max
//   m_axis   out  tdata: buttons, left_trigger, right_trigger,
//                        left_x, left_y, right_x, right_y
//
// Buttons, hat and unknown usages go from PREP straight to DONE. An axis in the
// deadzone or with zero range goes through PREP, CALC and DONE. Other axes also
// pass through DIV, a 50-step restoring divider sharing one 33-bit subtractor.
// One request in flight; the result waits in the output register, and the
// next result is held in DONE until the previous one is taken.
// Reset clears buttons, triggers and sticks to zero.
// ----------------------------------------------------------------------------
`include "hid_gamepad_report_mapper_macros.svh"

module hid_gamepad_report_mapper
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // usage[15:0], raw_value[47:16], logical_min[79:48], logical_max[111:80]
    input  logic [hgrm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[0], first_in_report[1]
    input  logic [hgrm_pkg::S_TUSER_W-1:0] s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // buttons[15:0], left_trigger[23:16], right_trigger[31:24], left_x[47:32],
    // left_y[63:48], right_x[79:64], right_y[95:80]
    output logic [hgrm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import hgrm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                     state_reg;

    // latched request
    target_t                    tgt_reg;
    logic                       first_reg;
    logic [USAGE_W-1:0]         usage_reg;
    logic [VAL_W-1:0]           raw_reg;
    logic [VAL_W-1:0]           min_reg;
    logic [VAL_W-1:0]           max_reg;

    // scaling datapath
    logic signed [RANGE_W-1:0]  range_reg;
    logic signed [RANGE_W-1:0]  offs_reg;
    logic                       mid_reg;
    logic                       neg_reg;
    logic [NUM_W-1:0]           quo_reg;
    logic [DEN_W:0]             rem_reg;
    logic [DEN_W-1:0]           den_reg;
    logic [CNT_W-1:0]           cnt_reg;

    // report state
    logic [15:0]                button_mask_reg;
    logic [7:0]                 lt_reg;
    logic [7:0]                 rt_reg;
    logic signed [15:0]         lx_reg;
    logic signed [15:0]         ly_reg;
    logic signed [15:0]         rx_reg;
    logic signed [15:0]         ry_reg;

    logic                       m_tvalid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;

    logic                       accept;
    logic                       out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // ---------------- PREP: buttons and hat ----------------
    logic [15:0] mask_base;
    logic        hat_in_range;
    logic [15:0] mask_prep;

    always_comb
    begin
        mask_base    = first_reg ? 16'h0000 : button_mask_reg;
        hat_in_range = (raw_reg >= min_reg) && (raw_reg <= max_reg);
        mask_prep    = mask_base;
        if (tgt_reg == TGT_BUTTON)
        begin
            mask_prep = mask_base | button_bit(usage_reg);
        end
        else if (tgt_reg == TGT_HAT && hat_in_range)
        begin
            mask_prep = mask_base | hat_bits(raw_reg);
        end
    end

    logic is_scaled;
    logic is_stick;

    assign is_stick  = (tgt_reg == TGT_LX) || (tgt_reg == TGT_LY) ||
                       (tgt_reg == TGT_RX) || (tgt_reg == TGT_RY);
    assign is_scaled = is_stick || (tgt_reg == TGT_LT) || (tgt_reg == TGT_RT);

    // ---------------- CALC: deadzone and numerator ----------------
    logic signed [RANGE_W-1:0] range_half;
    logic signed [RANGE_W:0]   diff;
    logic [RANGE_W:0]          diff_abs;
    logic [RANGE_W+4:0]        dz_plus1;
    logic [RANGE_W+4:0]        dz_lhs;
    logic                      dz_hit;
    logic signed [NUM_W:0]     offs_w;
    logic signed [NUM_W:0]     range_w;
    logic signed [NUM_W:0]     num_raw;
    logic signed [NUM_W:0]     num_adj;
    logic [NUM_W:0]            num_abs;
    logic [RANGE_W-1:0]        den_abs;

    always_comb
    begin
        // range/2 truncated toward zero
        range_half = (range_reg >>> 1) +
                     ((range_reg[RANGE_W-1] && range_reg[0]) ?
                      RANGE_W'(1) : RANGE_W'(0));
        diff     = (RANGE_W+1)'(offs_reg) - (RANGE_W+1)'(range_half);
        diff_abs = diff[RANGE_W] ? (RANGE_W+1)'(-diff) : (RANGE_W+1)'(diff);
        // |diff| < trunc(range/10)  <=>  10*(|diff|+1) <= range, range > 0
        dz_plus1 = (RANGE_W+5)'(diff_abs) + (RANGE_W+5)'(1);
        dz_lhs   = (dz_plus1 << 3) + (dz_plus1 << 1);
        dz_hit   = !range_reg[RANGE_W-1] && (dz_lhs <= (RANGE_W+5)'(range_reg));

        offs_w  = (NUM_W+1)'(offs_reg);
        range_w = (NUM_W+1)'(range_reg);
        // stick: offs*65535 - range*32768 ; trigger: offs*255
        if (is_stick)
            num_raw = (offs_w <<< 16) - offs_w - (range_w <<< 15);
        else
            num_raw = (offs_w <<< 8) - offs_w;
        num_adj = range_reg[RANGE_W-1] ? -num_raw : num_raw;
        num_abs = num_adj[NUM_W] ? (NUM_W+1)'(-num_adj) : (NUM_W+1)'(num_adj);
        den_abs = range_reg[RANGE_W-1] ? RANGE_W'(-range_reg) : RANGE_W'(range_reg);
    end

    // ---------------- DIV: one restoring step per cycle ----------------
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W+1:0] div_trial;
    logic             div_take;

    always_comb
    begin
        rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        div_trial = (DEN_W+2)'(rem_shift) - (DEN_W+2)'(den_reg);
        div_take  = !div_trial[DEN_W+1];
    end

    // ---------------- DONE: saturate and place ----------------
    logic signed [15:0] stick_val;
    logic signed [15:0] stick_neg;
    logic [7:0]         trig_val;
    logic [15:0]        q_low;
    logic signed [15:0] lx_new;
    logic signed [15:0] ly_new;
    logic signed [15:0] rx_new;
    logic signed [15:0] ry_new;
    logic [7:0]         lt_new;
    logic [7:0]         rt_new;

    always_comb
    begin
        q_low = quo_reg[15:0];
        priority if (mid_reg)
            stick_val = 16'sd0;
        else if (neg_reg && quo_reg > NUM_W'(32768))
            stick_val = STICK_MIN;
        else if (neg_reg)
            stick_val = -$signed(q_low);
        else if (quo_reg > NUM_W'(32767))
            stick_val = STICK_MAX;
        else
            stick_val = $signed(q_low);

        // negation saturates: the most negative value flips to the top
        stick_neg = (stick_val == STICK_MIN) ? STICK_MAX : -stick_val;

        priority if (mid_reg)
            trig_val = TRIG_MID;
        else if (neg_reg)
            trig_val = 8'd0;
        else if (quo_reg > NUM_W'(TRIG_MAX))
            trig_val = TRIG_MAX;
        else
            trig_val = quo_reg[7:0];

        lx_new = (tgt_reg == TGT_LX) ? stick_val : lx_reg;
        ly_new = (tgt_reg == TGT_LY) ? stick_neg : ly_reg;
        rx_new = (tgt_reg == TGT_RX) ? stick_val : rx_reg;
        ry_new = (tgt_reg == TGT_RY) ? stick_neg : ry_reg;
        lt_new = (tgt_reg == TGT_LT) ? trig_val  : lt_reg;
        rt_new = (tgt_reg == TGT_RT) ? trig_val  : rt_reg;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            button_mask_reg <= 16'h0000;
            lt_reg          <= 8'd0;
            rt_reg          <= 8'd0;
            lx_reg          <= 16'sd0;
            ly_reg          <= 16'sd0;
            rx_reg          <= 16'sd0;
            ry_reg          <= 16'sd0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        tgt_reg   <= decode_target(s_axis_tuser[0], s_axis_tdata[15:0]);
                        first_reg <= s_axis_tuser[1];
                        usage_reg <= s_axis_tdata[15:0];
                        raw_reg   <= s_axis_tdata[47:16];
                        min_reg   <= s_axis_tdata[79:48];
                        max_reg   <= s_axis_tdata[111:80];
                        state_reg <= ST_PREP;
                    end
                end

                ST_PREP:
                begin
                    button_mask_reg <= mask_prep;
                    if (first_reg)
                    begin
                        lt_reg <= 8'd0;
                        rt_reg <= 8'd0;
                    end
                    range_reg <= RANGE_W'($signed(max_reg)) - RANGE_W'($signed(min_reg));
                    offs_reg  <= RANGE_W'($signed(raw_reg)) - RANGE_W'($signed(min_reg));
                    mid_reg   <= 1'b0;
                    state_reg <= is_scaled ? ST_CALC : ST_DONE;
                end

                ST_CALC:
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    quo_reg <= num_abs[NUM_W-1:0];
                    den_reg <= den_abs[DEN_W-1:0];
                    neg_reg <= num_adj[NUM_W];
                    if (range_reg == '0 || dz_hit)
                    begin
                        mid_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    rem_reg <= div_take ? div_trial[DEN_W:0] : rem_shift;
                    quo_reg <= {quo_reg[NUM_W-2:0], div_take};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                        state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        lx_reg       <= lx_new;
                        ly_reg       <= ly_new;
                        rx_reg       <= rx_new;
                        ry_reg       <= ry_new;
                        lt_reg       <= lt_new;
                        rt_reg       <= rt_new;
                        m_tdata_reg  <= {ry_new, rx_new, ly_new, lx_new,
                                         rt_new, lt_new, button_mask_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------- assertions ----------------
    `HGRM_ASSERT_NXT(a_accept_to_prep, accept, state_reg == ST_PREP)
    `HGRM_ASSERT_IMP(a_div_rem_below_den, state_reg == ST_DIV, rem_reg < {1'b0, den_reg})
    `HGRM_ASSERT_IMP(a_result_from_done, $rose(m_axis_tvalid), $past(state_reg == ST_DONE))
    `HGRM_ASSERT_NXT(a_first_clears_triggers, state_reg == ST_PREP && first_reg,
                     lt_reg == 8'd0 && rt_reg == 8'd0)

endmodule
